// ===== rtl/core/fvn_pkg.sv =====
package fvn_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	// Park-Miller generator, Schrage form
	localparam logic [31:0]        SEED_OFFSET = 32'd12345;
	localparam logic [31:0]        PM_MASK     = 32'd123459876;
	localparam logic [31:0]        PM_Q        = 32'd127773;
	localparam logic signed [32:0] PM_A        = 33'sd16807;
	localparam logic signed [32:0] PM_R        = 33'sd2836;
	localparam logic signed [32:0] PM_M        = 33'sd2147483647;
	localparam int                 PM_STEPS    = 4;

	// exact floor(x / PM_Q) for x below 2^32 as (x * PM_RECIP) >> PM_SHIFT
	localparam int          PM_SHIFT    = 49;
	localparam logic [63:0] PM_RECIP_W  = ((64'd1 << PM_SHIFT) + 64'd127772) / 64'd127773;
	localparam logic [32:0] PM_RECIP    = PM_RECIP_W[32:0];

	// five stages per generator step, then fold, scale and shift
	localparam int CELL_LAT = PM_STEPS * 5 + 3;

	localparam int RATIO_FRAC = 16;

	typedef enum logic [2:0] {
		REG_BASE_AMP  = 3'd0,
		REG_BASE_FREQ = 3'd1,
		REG_OCT_COUNT = 3'd2,
		REG_AMP_RATIO = 3'd3
	} reg_idx_t;

endpackage

// ===== rtl/core/fvn_cell.sv =====
module fvn_cell (
	input  logic               clk,
	input  logic [31:0]        index,
	input  logic [31:0]        amp,
	output logic signed [31:0] value
);
	import fvn_pkg::*;

	logic signed [31:0] x_s1   [PM_STEPS];
	logic               neg_s2 [PM_STEPS];
	logic [31:0]        mag_s2 [PM_STEPS];
	logic               neg_s3 [PM_STEPS];
	logic [31:0]        mag_s3 [PM_STEPS];
	logic [64:0]        prod_s3[PM_STEPS];
	logic signed [15:0] k_s4   [PM_STEPS];
	logic signed [17:0] rem_s4 [PM_STEPS];
	logic signed [32:0] pa_s5  [PM_STEPS];
	logic signed [32:0] pb_s5  [PM_STEPS];

	logic signed [31:0] r_s21;
	logic signed [65:0] sc_s22;
	logic signed [31:0] value_s23;

	function automatic logic signed [31:0] pm_fold(input logic signed [32:0] a,
			input logic signed [32:0] b);
		logic signed [32:0] s;
		s = a - b;
		if (s < 0) begin
			s = s + PM_M;
		end
		return s[31:0];
	endfunction

	// the index is offset by SEED_OFFSET and masked with PM_MASK once, before the first step
	always_ff @(posedge clk) begin
		x_s1[0] <= $signed((index + SEED_OFFSET) ^ PM_MASK);
	end

	for (genvar n = 1; n < PM_STEPS; n++) begin : g_fold
		always_ff @(posedge clk) begin
			x_s1[n] <= pm_fold(pa_s5[n-1], pb_s5[n-1]);
		end
	end

	for (genvar n = 0; n < PM_STEPS; n++) begin : g_step
		logic [14:0] q;
		logic [31:0] rmag;

		always_comb begin
			q    = prod_s3[n][PM_SHIFT +: 15];
			rmag = mag_s3[n] - 32'(q) * PM_Q;
		end

		always_ff @(posedge clk) begin
			neg_s2[n]  <= x_s1[n][31];
			mag_s2[n]  <= x_s1[n][31] ? (~$unsigned(x_s1[n]) + 32'd1) : $unsigned(x_s1[n]);
			neg_s3[n]  <= neg_s2[n];
			mag_s3[n]  <= mag_s2[n];
			prod_s3[n] <= 65'(mag_s2[n]) * 65'(PM_RECIP);
			k_s4[n]    <= neg_s3[n] ? -$signed({1'b0, q}) : $signed({1'b0, q});
			rem_s4[n]  <= neg_s3[n] ? -$signed({1'b0, rmag[16:0]})
				: $signed({1'b0, rmag[16:0]});
			pa_s5[n]   <= 33'(rem_s4[n]) * PM_A;
			pb_s5[n]   <= 33'(k_s4[n]) * PM_R;
		end
	end

	always_ff @(posedge clk) begin
		r_s21     <= pm_fold(pa_s5[PM_STEPS-1], pb_s5[PM_STEPS-1]);
		sc_s22    <= 66'(33'(r_s21) - 33'sd1073741824) * 66'($signed({1'b0, amp}));
		value_s23 <= sc_s22[62:31];
	end

	assign value = value_s23;

endmodule

// ===== rtl/core/fractal_value_noise_1d.sv =====
// Fractal 1-D value noise. One position word is taken on every clock that start is high
// (busy never rises) and its result appears on noise_value/saturated with done high once it
// has passed the four Park-Miller steps of each cell generator (five stages each) and one
// adder stage per octave in the summing chain. All octaves run as parallel lanes, so the
// rate is one word per clock whatever octave_count holds. Write configuration only while no
// word is in flight; the octave amplitudes are rebuilt from base_amplitude and
// amplitude_ratio through a chain of registered multiplies after a write.
module fractal_value_noise_1d #(
	parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] position,
	output logic               done,
	output logic signed [31:0] noise_value,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import fvn_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int HW    = F + 2;
	localparam int MIX_W = 36 + F;
	localparam int SUM_W = 35 + $clog2(MAX_OCTAVES);
	localparam int LAT   = 3 + CELL_LAT + 3 + MAX_OCTAVES + 1;

	logic [31:0] base_amp_q;
	logic [31:0] base_freq_q;
	logic [3:0]  oct_q;
	logic [17:0] ratio_q;
	logic [31:0] amp_q [MAX_OCTAVES];

	logic [LAT-1:0] vld_q;

	logic signed [31:0]  pos_s1;
	logic signed [63:0]  prod_s2;
	logic signed [127:0] pw;

	logic [31:0]        idxa_s3 [MAX_OCTAVES];
	logic [31:0]        idxb_s3 [MAX_OCTAVES];
	logic [F-1:0]       t_s3    [MAX_OCTAVES];
	logic [F-1:0]       t_s4    [MAX_OCTAVES];
	logic [F-1:0]       t2_s4   [MAX_OCTAVES];
	logic [F-1:0]       t2_s5   [MAX_OCTAVES];
	logic [F-1:0]       t3_s5   [MAX_OCTAVES];
	logic [HW-1:0]      h_s6    [MAX_OCTAVES];
	logic [HW-1:0]      h_dly_q [MAX_OCTAVES][CELL_LAT-3];
	logic signed [31:0] ya_c    [MAX_OCTAVES];
	logic signed [31:0] yb_c    [MAX_OCTAVES];
	logic signed [32:0] diff_s27[MAX_OCTAVES];
	logic signed [31:0] ya_s27  [MAX_OCTAVES];
	logic [HW-1:0]      h_s27   [MAX_OCTAVES];
	logic signed [MIX_W-1:0] mix_s28[MAX_OCTAVES];
	logic signed [31:0] ya_s28  [MAX_OCTAVES];
	logic signed [33:0] term_s29[MAX_OCTAVES];

	// sum chain: element j is one adder stage further on
	logic signed [SUM_W-1:0] sum_s30  [MAX_OCTAVES];
	logic signed [33:0]      tail_s30 [MAX_OCTAVES][MAX_OCTAVES];

	logic signed [SUM_W-1:0] total;
	logic                    clip;
	logic signed [31:0]      res_q;
	logic                    sat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_amp_q  <= 32'd65536;
			base_freq_q <= 32'd65536;
			oct_q       <= 4'd1;
			ratio_q     <= 18'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_AMP:  base_amp_q  <= cfg_data;
				REG_BASE_FREQ: base_freq_q <= cfg_data;
				REG_OCT_COUNT: oct_q       <= cfg_data[3:0];
				REG_AMP_RATIO: ratio_q     <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// octave amplitudes follow the registers through a chain of multiplies
	always_ff @(posedge clk) begin
		amp_q[0] <= base_amp_q;
	end

	for (genvar i = 1; i < MAX_OCTAVES; i++) begin : g_amp
		logic [49:0] ap;
		always_comb begin
			ap = 50'(amp_q[i-1]) * 50'(ratio_q);
		end
		always_ff @(posedge clk) begin
			amp_q[i] <= (|ap[49:RATIO_FRAC+32]) ? 32'hFFFF_FFFF : ap[RATIO_FRAC +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= position;
		prod_s2 <= 64'(65'(pos_s1) * 65'($signed({1'b0, base_freq_q})));
	end

	assign pw = 128'(prod_s2);

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		logic [127:0] qsh;
		assign qsh = pw << i;

		always_ff @(posedge clk) begin
			idxa_s3[i] <= qsh[2*F +: 32];
			idxb_s3[i] <= qsh[2*F +: 32] + 32'd1;
			t_s3[i]    <= qsh[F +: F];
			t_s4[i]    <= t_s3[i];
			t2_s4[i]   <= F'(((2*F)'(t_s3[i]) * (2*F)'(t_s3[i])) >> F);
			t2_s5[i]   <= t2_s4[i];
			t3_s5[i]   <= F'(((2*F)'(t2_s4[i]) * (2*F)'(t_s4[i])) >> F);
			h_s6[i]    <= (HW'(t2_s5[i]) << 1) + HW'(t2_s5[i]) - (HW'(t3_s5[i]) << 1);
			h_dly_q[i][0] <= h_s6[i];
		end

		for (genvar d = 1; d < CELL_LAT - 3; d++) begin : g_hd
			always_ff @(posedge clk) begin
				h_dly_q[i][d] <= h_dly_q[i][d-1];
			end
		end

		fvn_cell u_cell_a (
			.clk   (clk),
			.index (idxa_s3[i]),
			.amp   (amp_q[i]),
			.value (ya_c[i])
		);

		fvn_cell u_cell_b (
			.clk   (clk),
			.index (idxb_s3[i]),
			.amp   (amp_q[i]),
			.value (yb_c[i])
		);

		always_ff @(posedge clk) begin
			diff_s27[i] <= 33'(yb_c[i]) - 33'(ya_c[i]);
			ya_s27[i]   <= ya_c[i];
			h_s27[i]    <= h_dly_q[i][CELL_LAT-4];
			mix_s28[i]  <= MIX_W'(diff_s27[i]) * MIX_W'($signed({1'b0, h_s27[i]}));
			ya_s28[i]   <= ya_s27[i];
			// drop octaves beyond the configured count
			term_s29[i] <= (oct_q > 4'(i)) ? 34'(ya_s28[i]) + 34'(mix_s28[i] >>> F) : '0;
		end
	end

	always_ff @(posedge clk) begin
		sum_s30[0]  <= SUM_W'(term_s29[0]);
		tail_s30[0] <= term_s29;
	end

	for (genvar j = 1; j < MAX_OCTAVES; j++) begin : g_sum
		always_ff @(posedge clk) begin
			sum_s30[j]  <= sum_s30[j-1] + SUM_W'(tail_s30[j-1][j]);
			tail_s30[j] <= tail_s30[j-1];
		end
	end

	always_comb begin
		total = sum_s30[MAX_OCTAVES-1];
		clip  = !((&total[SUM_W-1:31]) || !(|total[SUM_W-1:31]));
	end

	always_ff @(posedge clk) begin
		res_q <= clip ? (total[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : total[31:0];
		sat_q <= clip;
	end

	assign done        = vld_q[LAT-1];
	assign noise_value = res_q;
	assign saturated   = sat_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result word missing after fixed latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a matching input word");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (noise_value == 32'sh7FFF_FFFF || noise_value == 32'sh8000_0000))
		else $error("saturated word not at a range limit");

	a_zero_oct: assert property (@(posedge clk) disable iff (!arst_n)
		(done && oct_q == 4'd0) |-> (noise_value == 32'sd0 && !saturated))
		else $error("zero octaves must give zero");
`endif

endmodule
